/* rtl/iiv_pkg.sv */
`default_nettype none

package iiv_pkg;

  // list shape
  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // fixed port field widths
  localparam int CMD_W      = 3;
  localparam int POS_W      = 5;
  localparam int WORD_IN_W  = 32;
  localparam int WORD_OUT_W = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int CMP_W      = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam int IN_DATA_W  = ((POS_W + WORD_IN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((WORD_OUT_W + STATUS_W + COUNT_W + 1 + 7) / 8) * 8;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_POP    = 3'd1,
    CMD_READ   = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // write command broadcast to every cell
  typedef struct packed {
    logic             wr;
    logic [IDX_W-1:0] pos;
    word_t            word;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/iiv_cell.sv */
`default_nettype none

module iiv_cell
  import iiv_pkg::*;
(
  input  wire logic             clk,
  input  wire cell_ctl_t        ctl,
  input  wire logic [IDX_W-1:0] idx,
  input  wire word_t            prev,
  output word_t                 q
);

  // at the write position take the new word, above it take the lower neighbor
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      if (idx == ctl.pos) begin
        q <= ctl.word;
      end else if (idx > ctl.pos) begin
        q <= prev;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/indexed_insert_vector.sv */
// Fixed-capacity ordered list of words held in a row of cells.
//
// Request channel (s_axis_*): s_axis_tuser carries the command (append, pop,
// read, insert, clear); s_axis_tdata carries the position and the word.
// Result channel (m_axis_*): one result per request with the word read,
// a status code, the length after the request and an empty flag.
//
// Each request is done at the edge that accepts it: the whole cell row
// updates at that single edge (an insert moves every later entry up one cell
// at once), and the result lands in the output register on that edge.
// Throughput is one request per cycle while the result side takes them.
//
// When the receiver stalls, the held result stays on m_axis_* and
// s_axis_tready drops until it is taken. Reset empties the list and drops
// the result valid; the cell contents are not cleared, since only entries
// below the length can be read.
`default_nettype none

module indexed_insert_vector
  import iiv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [4:0] position, [36:5] word_in, rest zero
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [2:0] cmd
  input  wire logic [CMD_W-1:0]      s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [31:0] word_out, [33:32] status, [38:34] count, [39] is_empty
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  logic [CNT_W-1:0]      fill;
  logic [CNT_W-1:0]      fill_next;
  logic                  accept;
  cmd_t                  cmd;
  logic [POS_W-1:0]      position;
  logic [WORD_IN_W-1:0]  word_in;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      fill_ext;
  logic                  full;
  status_t               status_next;
  word_t                 rd_word;
  cell_ctl_t             ctl;
  word_t                 cell_q [DEPTH];

  logic [WORD_OUT_W-1:0] word_out;
  status_t               status;
  logic [COUNT_W-1:0]    count;
  logic                  is_empty;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign cmd      = cmd_t'(s_axis_tuser);
  assign position = s_axis_tdata[POS_W-1:0];
  assign word_in  = s_axis_tdata[POS_W +: WORD_IN_W];
  assign pos_ext  = CMP_W'(position);
  assign fill_ext = CMP_W'(fill);
  assign full     = (fill == CNT_W'(DEPTH));

  always_comb begin
    status_next = ST_OK;
    fill_next   = fill;
    rd_word     = '0;
    ctl.wr      = 1'b0;
    ctl.pos     = fill[IDX_W-1:0];
    ctl.word    = WORD_BITS'(word_in);
    unique case (cmd)
      CMD_APPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.wr    = accept;
          fill_next = fill + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (fill == '0) begin
          status_next = ST_EMPTY;
        end else begin
          fill_next = fill - CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (pos_ext >= fill_ext) begin
          status_next = ST_RANGE;
        end else begin
          rd_word = cell_q[pos_ext[IDX_W-1:0]];
        end
      end
      CMD_INSERT: begin
        if (pos_ext > fill_ext) begin
          status_next = ST_RANGE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.wr    = accept;
          ctl.pos   = pos_ext[IDX_W-1:0];
          fill_next = fill + CNT_W'(1);
        end
      end
      CMD_CLEAR: begin
        fill_next = '0;
      end
      default: begin
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      word_t prev;
      if (gi == 0) begin : g_first
        assign prev = '0;
      end else begin : g_rest
        assign prev = cell_q[gi-1];
      end
      iiv_cell u_cell (
        .clk  (clk),
        .ctl  (ctl),
        .idx  (IDX_W'(gi)),
        .prev (prev),
        .q    (cell_q[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        fill          <= fill_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // result payload, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (accept) begin
      word_out <= WORD_OUT_W'(rd_word);
      status   <= status_next;
      count    <= COUNT_W'(fill_next);
      is_empty <= (fill_next == '0);
    end
  end

  assign m_axis_tdata = OUT_DATA_W'({is_empty, count, status, word_out});

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("list length beyond capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (is_empty == (count == '0)))
    else $error("empty flag disagrees with count");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_CLEAR) |=> (fill == '0))
    else $error("clear left entries");

  a_pop: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_POP && fill != '0) |=> (fill == $past(fill) - CNT_W'(1)))
    else $error("pop did not shorten list");

  a_count_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    accept |=> (count == COUNT_W'(fill)))
    else $error("reported count differs from length");

endmodule

`default_nettype wire
